/* rtl/spp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// spp_pkg: shared types and constants of the splash particle pool
// Pool geometry, generator constants, command and state codes, helpers.
// ---------------------------------------------------------------------------
package spp_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int SLOT_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = (SLOT_W + 1 > 7) ? SLOT_W + 1 : 7;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [63:0]        GOLDEN_SEED   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0]        MIX_MULT      = 64'h2545_F491_4F6C_DD1D;
    localparam logic signed [31:0] GRAVITY_RESET = 32'sd642253;
    localparam logic [MUL_W-1:0]   RECIP5        = 34'h0_3333_3333;
    localparam logic [29:0]        BASE_MIN      = 30'd98304;

    typedef enum logic [1:0] {
        CMD_SPAWN  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    localparam logic REG_SEED    = 1'b0;
    localparam logic REG_GRAVITY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIN,
        S_SP_SCAN,
        S_DR_X,
        S_DR_M1,
        S_DR_M2,
        S_DR_M3,
        S_USE,
        S_SPR,
        S_VY1,
        S_DV_MUL,
        S_DV_FIX,
        S_TK_SCAN,
        S_TK_LIFE,
        S_TK_VY,
        S_TK_PX,
        S_TK_PY,
        S_TK_PZ,
        S_RD1,
        S_RD2
    } t_state;

    typedef enum logic [1:0] {
        DR_BASE,
        DR_VY,
        DR_LIFE
    } t_dret;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        logic [63:0] x;
        x = v ^ (v >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [34:0] ext35(input logic signed [31:0] v);
        return {{3{v[31]}}, v};
    endfunction

endpackage
`default_nettype wire

/* rtl/spp_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// spp_if: request and response channels of the splash particle pool
// Valid/ready channels carrying one request or one response each.
// ---------------------------------------------------------------------------
interface spp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] hit_speed;
    logic [6:0]         burst_size;
    logic [16:0]        step_time;
    logic [5:0]         slot_index;

    modport source (output valid, cmd, origin_x, origin_y, origin_z, hit_speed,
                    burst_size, step_time, slot_index, input ready);
    modport sink (input valid, cmd, origin_x, origin_y, origin_z, hit_speed,
                  burst_size, step_time, slot_index, output ready);
endinterface

interface spp_out_if;
    logic               valid;
    logic               ready;
    logic [6:0]         tally;
    logic [6:0]         scan_limit;
    logic signed [31:0] slot_x;
    logic signed [31:0] slot_y;
    logic signed [31:0] slot_z;
    logic [16:0]        slot_life;

    modport source (output valid, tally, scan_limit, slot_x, slot_y, slot_z, slot_life,
                    input ready);
    modport sink (input valid, tally, scan_limit, slot_x, slot_y, slot_z, slot_life,
                  output ready);
endinterface
`default_nettype wire

/* rtl/spp_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// spp_ram: one slot store of the pool
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module spp_ram
    import spp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [SLOT_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [SLOT_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [POOL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/spp_mul.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// spp_mul: shared signed multiplier
// One registered signed product per cycle for the sequencer.
// ---------------------------------------------------------------------------
module spp_mul
    import spp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [MUL_W-1:0]  i_a,
    input  wire logic signed [MUL_W-1:0]  i_b,
    output logic signed      [PROD_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

/* rtl/splash_particle_pool.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// splash_particle_pool: fixed pool of splash particles in Q16.16
// Spawn and tick requests run on one shared multiplier.
//
//   channel    dir  handshake        contents
//   i_req_ch   in   valid/ready      cmd, origin, impact, burst, dt, slot
//   o_rsp_ch   out  valid/ready      tally, scan_limit, slot fields
//   APB        in   psel/penable     seed_value at 0x0, gravity_accel at 0x8
//
// Spawn probes slots in order and places a particle in each free one; the
// three multiply passes of each generator draw dominate its work. Tick
// skips free slots below the scan top, clears each slot that expires and
// updates each surviving slot with four multiplies. Read and status need
// no multiply and hand over the response through its register. Reset and seed
// writes clear the pool at once.
// A finished response waits in its register; a new request is taken then.
// ---------------------------------------------------------------------------
module splash_particle_pool
    import spp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    spp_in_if.sink           i_req_ch,
    spp_out_if.source        o_rsp_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    t_state                 r_state, n_state;
    t_dret                  r_ret, n_ret;
    t_cmd                   r_cmd, n_cmd;
    logic signed [31:0]     r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic [6:0]             r_want, n_want;
    logic [16:0]            r_dt, n_dt;
    logic [29:0]            r_base, n_base;
    logic [63:0]            r_rng, n_rng, r_seed, n_seed, r_acc, n_acc;
    logic signed [31:0]     r_grav, n_grav;
    logic [23:0]            r_r, n_r;
    logic [32:0]            r_y, n_y;
    logic [1:0]             r_dn, n_dn;
    logic signed [31:0]     r_vy, n_vy;
    logic [CNT_W-1:0]       r_slot, n_slot, r_scan, n_scan, r_top, n_top;
    logic [CNT_W-1:0]       r_live, n_live;
    logic [6:0]             r_tally, n_tally;
    logic signed [31:0]     r_rx, n_rx, r_ry, n_ry, r_rz, n_rz;
    logic [16:0]            r_rlife, n_rlife;
    logic [POOL_DEPTH-1:0]  r_alive, n_alive, r_wrt, n_wrt;
    logic                   r_ov, n_ov;
    logic [6:0]             r_o_tally, n_o_tally, r_o_scan, n_o_scan;
    logic signed [31:0]     r_o_x, n_o_x, r_o_y, n_o_y, r_o_z, n_o_z;
    logic [16:0]            r_o_life, n_o_life;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod, prod_rnd, prod_sh;
    logic [SLOT_W-1:0]        slot_a;
    logic [63:0]              xs, acc_sum;
    logic [30:0]              q0, dq;
    logic [33:0]              rem;
    logic signed [24:0]       cen;
    logic signed [34:0]       step35;
    logic signed [31:0]       vy_new, spr_v;
    logic                     accept, cfg_wr;

    logic                     we_px, we_py, we_pz, we_vx, we_vy, we_vz, we_life;
    logic signed [31:0]       wd_px, wd_py, wd_pz, wd_vx, wd_vy, wd_vz;
    logic [16:0]              wd_life;
    logic [31:0]              rd_px, rd_py, rd_pz, rd_vx, rd_vy, rd_vz;
    logic [16:0]              rd_life;

    spp_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    spp_ram #(.WIDTH(32)) u_px (.i_clk(i_clk), .i_we(we_px), .i_waddr(slot_a),
        .i_wdata(wd_px), .i_raddr(slot_a), .o_rdata(rd_px));
    spp_ram #(.WIDTH(32)) u_py (.i_clk(i_clk), .i_we(we_py), .i_waddr(slot_a),
        .i_wdata(wd_py), .i_raddr(slot_a), .o_rdata(rd_py));
    spp_ram #(.WIDTH(32)) u_pz (.i_clk(i_clk), .i_we(we_pz), .i_waddr(slot_a),
        .i_wdata(wd_pz), .i_raddr(slot_a), .o_rdata(rd_pz));
    spp_ram #(.WIDTH(32)) u_vx (.i_clk(i_clk), .i_we(we_vx), .i_waddr(slot_a),
        .i_wdata(wd_vx), .i_raddr(slot_a), .o_rdata(rd_vx));
    spp_ram #(.WIDTH(32)) u_vy (.i_clk(i_clk), .i_we(we_vy), .i_waddr(slot_a),
        .i_wdata(wd_vy), .i_raddr(slot_a), .o_rdata(rd_vy));
    spp_ram #(.WIDTH(32)) u_vz (.i_clk(i_clk), .i_we(we_vz), .i_waddr(slot_a),
        .i_wdata(wd_vz), .i_raddr(slot_a), .o_rdata(rd_vz));
    spp_ram #(.WIDTH(17)) u_life (.i_clk(i_clk), .i_we(we_life), .i_waddr(slot_a),
        .i_wdata(wd_life), .i_raddr(slot_a), .o_rdata(rd_life));

    assign slot_a = r_slot[SLOT_W-1:0];
    assign accept = i_req_ch.valid && (r_state == S_IDLE);
    assign cfg_wr = psel && penable && pwrite;

    assign i_req_ch.ready      = (r_state == S_IDLE);
    assign o_rsp_ch.valid      = r_ov;
    assign o_rsp_ch.tally      = r_o_tally;
    assign o_rsp_ch.scan_limit = r_o_scan;
    assign o_rsp_ch.slot_x     = r_o_x;
    assign o_rsp_ch.slot_y     = r_o_y;
    assign o_rsp_ch.slot_z     = r_o_z;
    assign o_rsp_ch.slot_life  = r_o_life;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_SEED) ? r_seed : {{32{r_grav[31]}}, r_grav};

    always_comb begin
        xs       = xorshift(r_rng);
        acc_sum  = r_acc + {prod[31:0], 32'b0};
        q0       = prod[62:32];
        rem      = {1'b0, r_y} - ({1'b0, q0, 2'b0} + {3'b0, q0});
        dq       = (rem >= 34'd5) ? q0 + 31'd1 : q0;
        cen      = $signed({1'b0, r_r}) - 25'sd8388608;
        prod_sh  = prod >>> 16;
        step35   = prod_sh[34:0];
        vy_new   = sat32(ext35($signed(rd_vy)) - step35);
        prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(24'hFF_FFFF) : PROD_W'(0));
        prod_sh  = prod_rnd >>> 24;
        spr_v    = prod_sh[31:0];
        prod_sh  = prod >>> 16;
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_cmd = r_cmd;
        n_ox = r_ox;         n_oy = r_oy;       n_oz = r_oz;
        n_want = r_want;     n_dt = r_dt;       n_base = r_base;
        n_rng = r_rng;       n_seed = r_seed;   n_acc = r_acc;
        n_grav = r_grav;     n_r = r_r;         n_y = r_y;
        n_dn = r_dn;         n_vy = r_vy;       n_slot = r_slot;
        n_scan = r_scan;     n_top = r_top;     n_live = r_live;
        n_tally = r_tally;   n_rx = r_rx;       n_ry = r_ry;
        n_rz = r_rz;         n_rlife = r_rlife; n_alive = r_alive;
        n_wrt = r_wrt;       n_ov = r_ov;
        n_o_tally = r_o_tally; n_o_scan = r_o_scan; n_o_x = r_o_x;
        n_o_y = r_o_y;       n_o_z = r_o_z;     n_o_life = r_o_life;
        mul_a = '0;          mul_b = '0;
        we_px = 1'b0; we_py = 1'b0; we_pz = 1'b0;
        we_vx = 1'b0; we_vy = 1'b0; we_vz = 1'b0; we_life = 1'b0;
        wd_px = r_ox; wd_py = r_oy; wd_pz = r_oz;
        wd_vx = spr_v; wd_vy = vy_new; wd_vz = spr_v;
        wd_life = rd_life - r_dt;

        if (o_rsp_ch.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = t_cmd'(i_req_ch.cmd);
                    n_ox    = i_req_ch.origin_x;
                    n_oy    = i_req_ch.origin_y;
                    n_oz    = i_req_ch.origin_z;
                    n_want  = i_req_ch.burst_size;
                    n_dt    = i_req_ch.step_time;
                    n_tally = '0;
                    n_rx    = '0;
                    n_ry    = '0;
                    n_rz    = '0;
                    n_rlife = '0;
                    n_slot  = '0;
                    n_top   = '0;
                    case (t_cmd'(i_req_ch.cmd))
                        CMD_SPAWN: begin
                            n_y = i_req_ch.hit_speed[31]
                                ? 33'd0 - {1'b1, i_req_ch.hit_speed}
                                : {1'b0, i_req_ch.hit_speed};
                            n_y = {n_y[31:0], 1'b0};
                            n_ret   = DR_BASE;
                            n_state = S_DV_MUL;
                        end
                        CMD_TICK: begin
                            n_state = S_TK_SCAN;
                        end
                        CMD_READ: begin
                            n_slot  = CNT_W'(i_req_ch.slot_index);
                            n_tally = r_live[6:0];
                            n_state = S_RD1;
                        end
                        default: begin
                            n_tally = r_live[6:0];
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DV_MUL: begin
                mul_a   = {1'b0, r_y};
                mul_b   = RECIP5;
                n_state = S_DV_FIX;
            end
            S_DV_FIX: begin
                case (r_ret)
                    DR_BASE: begin
                        n_base  = BASE_MIN + dq[29:0];
                        n_state = S_SP_SCAN;
                    end
                    DR_VY: begin
                        we_vy   = 1'b1;
                        wd_vy   = {1'b0, dq};
                        n_dn    = 2'd3;
                        n_state = S_DR_X;
                    end
                    default: begin
                        we_life          = 1'b1;
                        wd_life          = dq[16:0];
                        n_alive[slot_a]  = 1'b1;
                        n_live           = r_live + CNT_W'(1);
                        n_tally          = r_tally + 7'd1;
                        n_slot           = r_slot + CNT_W'(1);
                        n_state          = S_SP_SCAN;
                    end
                endcase
            end
            S_SP_SCAN: begin
                if (r_tally == r_want || r_slot >= CNT_W'(POOL_DEPTH)) begin
                    n_state = S_FIN;
                end else if (r_alive[slot_a]) begin
                    n_slot = r_slot + CNT_W'(1);
                end else begin
                    we_px          = 1'b1;
                    we_py          = 1'b1;
                    we_pz          = 1'b1;
                    n_wrt[slot_a]  = 1'b1;
                    if (r_slot + CNT_W'(1) > r_scan) begin
                        n_scan = r_slot + CNT_W'(1);
                    end
                    n_dn    = 2'd0;
                    n_state = S_DR_X;
                end
            end
            S_DR_X: begin
                mul_a   = {2'b0, xs[31:0]};
                mul_b   = {2'b0, MIX_MULT[31:0]};
                n_rng   = xs;
                n_state = S_DR_M1;
            end
            S_DR_M1: begin
                n_acc   = prod[63:0];
                mul_a   = {2'b0, r_rng[63:32]};
                mul_b   = {2'b0, MIX_MULT[31:0]};
                n_state = S_DR_M2;
            end
            S_DR_M2: begin
                n_acc   = acc_sum;
                mul_a   = {2'b0, r_rng[31:0]};
                mul_b   = {2'b0, MIX_MULT[63:32]};
                n_state = S_DR_M3;
            end
            S_DR_M3: begin
                n_r     = acc_sum[63:40];
                n_state = S_USE;
            end
            S_USE: begin
                case (r_dn)
                    2'd0, 2'd1: begin
                        mul_a   = {{9{cen[24]}}, cen};
                        mul_b   = {4'b0, r_base};
                        n_state = S_SPR;
                    end
                    2'd2: begin
                        mul_a   = {4'b0, r_base};
                        mul_b   = MUL_W'(27'd50331648 + {2'b0, r_r, 1'b0});
                        n_state = S_VY1;
                    end
                    default: begin
                        n_y     = 33'(({2'b0, r_r, 1'b0} + {3'b0, r_r} + 27'd33554432) >> 8);
                        n_ret   = DR_LIFE;
                        n_state = S_DV_MUL;
                    end
                endcase
            end
            S_SPR: begin
                if (r_dn == 2'd0) begin
                    we_vx = 1'b1;
                    n_dn  = 2'd1;
                end else begin
                    we_vz = 1'b1;
                    n_dn  = 2'd2;
                end
                n_state = S_DR_X;
            end
            S_VY1: begin
                n_y     = prod[56:24];
                n_ret   = DR_VY;
                n_state = S_DV_MUL;
            end
            S_TK_SCAN: begin
                if (r_slot >= r_scan) begin
                    n_scan  = r_top;
                    n_state = S_FIN;
                end else if (!r_alive[slot_a]) begin
                    n_slot = r_slot + CNT_W'(1);
                end else begin
                    n_state = S_TK_LIFE;
                end
            end
            S_TK_LIFE: begin
                if (rd_life <= r_dt) begin
                    n_alive[slot_a] = 1'b0;
                    n_live          = r_live - CNT_W'(1);
                    n_slot          = r_slot + CNT_W'(1);
                    n_state         = S_TK_SCAN;
                end else begin
                    we_life = 1'b1;
                    mul_a   = {{2{r_grav[31]}}, r_grav};
                    mul_b   = {17'b0, r_dt};
                    n_state = S_TK_VY;
                end
            end
            S_TK_VY: begin
                we_vy   = 1'b1;
                n_vy    = vy_new;
                mul_a   = {{2{rd_vx[31]}}, rd_vx};
                mul_b   = {17'b0, r_dt};
                n_state = S_TK_PX;
            end
            S_TK_PX: begin
                we_px   = 1'b1;
                wd_px   = sat32(ext35($signed(rd_px)) + step35);
                mul_a   = {{2{r_vy[31]}}, r_vy};
                mul_b   = {17'b0, r_dt};
                n_state = S_TK_PY;
            end
            S_TK_PY: begin
                we_py   = 1'b1;
                wd_py   = sat32(ext35($signed(rd_py)) + step35);
                mul_a   = {{2{rd_vz[31]}}, rd_vz};
                mul_b   = {17'b0, r_dt};
                n_state = S_TK_PZ;
            end
            S_TK_PZ: begin
                we_pz   = 1'b1;
                wd_pz   = sat32(ext35($signed(rd_pz)) + step35);
                n_tally = r_tally + 7'd1;
                n_top   = r_slot + CNT_W'(1);
                n_slot  = r_slot + CNT_W'(1);
                n_state = S_TK_SCAN;
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                if (r_slot < CNT_W'(POOL_DEPTH)) begin
                    if (r_wrt[slot_a]) begin
                        n_rx = rd_px;
                        n_ry = rd_py;
                        n_rz = rd_pz;
                    end
                    if (r_alive[slot_a]) begin
                        n_rlife = rd_life;
                    end
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_rsp_ch.ready) begin
                    n_ov      = 1'b1;
                    n_o_tally = r_tally;
                    n_o_scan  = r_scan[6:0];
                    n_o_x     = r_rx;
                    n_o_y     = r_ry;
                    n_o_z     = r_rz;
                    n_o_life  = r_rlife;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            if (paddr[3] == REG_SEED) begin
                n_seed  = pwdata;
                n_rng   = (pwdata != 64'd0) ? pwdata : GOLDEN_SEED;
                n_alive = '0;
                n_wrt   = '0;
                n_scan  = '0;
                n_live  = '0;
            end else begin
                n_grav = pwdata[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rng   <= GOLDEN_SEED;
            r_seed  <= '0;
            r_grav  <= GRAVITY_RESET;
            r_alive <= '0;
            r_wrt   <= '0;
            r_scan  <= '0;
            r_live  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rng   <= n_rng;
            r_seed  <= n_seed;
            r_grav  <= n_grav;
            r_alive <= n_alive;
            r_wrt   <= n_wrt;
            r_scan  <= n_scan;
            r_live  <= n_live;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;     r_cmd <= n_cmd;
        r_ox <= n_ox;       r_oy <= n_oy;       r_oz <= n_oz;
        r_want <= n_want;   r_dt <= n_dt;       r_base <= n_base;
        r_acc <= n_acc;     r_r <= n_r;         r_y <= n_y;
        r_dn <= n_dn;       r_vy <= n_vy;       r_slot <= n_slot;
        r_top <= n_top;     r_tally <= n_tally;
        r_rx <= n_rx;       r_ry <= n_ry;       r_rz <= n_rz;
        r_rlife <= n_rlife;
        r_o_tally <= n_o_tally; r_o_scan <= n_o_scan;
        r_o_x <= n_o_x;     r_o_y <= n_o_y;     r_o_z <= n_o_z;
        r_o_life <= n_o_life;
    end

endmodule
`default_nettype wire

/* sim/splash_particle_pool_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// splash_particle_pool_checker: response checker of the splash particle pool
// Watches the request and response channels, predicts each response with
// its own model of the pool and compares it field by field.
// ---------------------------------------------------------------------------
module splash_particle_pool_checker
    import spp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    spp_in_if.sink           i_req_mon,
    spp_out_if.sink          i_rsp_mon,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [6:0]         tally;
        logic [6:0]         scan_limit;
        logic signed [31:0] slot_x;
        logic signed [31:0] slot_y;
        logic signed [31:0] slot_z;
        logic [16:0]        slot_life;
    } t_rsp;

    logic signed [31:0] px[POOL_DEPTH], py[POOL_DEPTH], pz[POOL_DEPTH];
    logic signed [31:0] vx[POOL_DEPTH], vy[POOL_DEPTH], vz[POOL_DEPTH];
    logic [16:0]        life[POOL_DEPTH];
    logic [63:0]        gen_word;
    int                 top_slot;
    logic signed [31:0] gravity;
    t_rsp               expected_rsps[$];

    assign o_pending = expected_rsps.size();

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint floor_frac(input longint v);
        return v >>> 16;
    endfunction

    task automatic clear_particles();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            px[i] = 0; py[i] = 0; pz[i] = 0;
            vx[i] = 0; vy[i] = 0; vz[i] = 0;
            life[i] = 0;
        end
        top_slot = 0;
    endtask

    function automatic longint next_draw();
        logic [63:0] x;
        logic [127:0] prod;
        x = gen_word;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        gen_word = x;
        prod = x * MIX_MULT;
        return longint'(prod[63:40]);
    endfunction

    function automatic int count_live();
        int n;
        n = 0;
        for (int i = 0; i < top_slot; i++) begin
            if (life[i] != 0) n++;
        end
        return n;
    endfunction

    task automatic predict_request(input t_rsp r, input logic [1:0] cmd,
                                   input logic signed [31:0] ox, input logic signed [31:0] oy,
                                   input logic signed [31:0] oz, input logic signed [31:0] imp,
                                   input logic [6:0] burst, input logic [16:0] dt,
                                   input logic [5:0] idx);
        longint mag, base, d, dtl;
        int slot, placed, top;
        r = '0;
        if (cmd == CMD_SPAWN) begin
            mag = longint'(imp);
            if (mag < 0) mag = -mag;
            base = 98304 + (2 * mag) / 5;
            placed = 0;
            while (placed < burst) begin
                slot = POOL_DEPTH;
                for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
                    if (life[i] == 0) slot = i;
                end
                if (slot >= POOL_DEPTH) break;
                if (slot + 1 > top_slot) top_slot = slot + 1;
                px[slot] = ox; py[slot] = oy; pz[slot] = oz;
                vx[slot] = 32'((next_draw() - 8388608) * base / 16777216);
                vz[slot] = 32'((next_draw() - 8388608) * base / 16777216);
                d = next_draw();
                vy[slot] = 32'(base * (50331648 + 2 * d) / 83886080);
                d = next_draw();
                life[slot] = 17'(65536 * (33554432 + 3 * d) / 83886080);
                placed++;
            end
            r.tally = 7'(placed);
        end else if (cmd == CMD_TICK) begin
            dtl = longint'(dt);
            top = 0;
            placed = 0;
            for (int i = 0; i < top_slot; i++) begin
                if (life[i] == 0) continue;
                if (longint'(life[i]) <= dtl) begin
                    life[i] = 0;
                    continue;
                end
                life[i] = life[i] - dt;
                vy[i] = clamp32(longint'(vy[i]) - floor_frac(longint'(gravity) * dtl));
                px[i] = clamp32(longint'(px[i]) + floor_frac(longint'(vx[i]) * dtl));
                py[i] = clamp32(longint'(py[i]) + floor_frac(longint'(vy[i]) * dtl));
                pz[i] = clamp32(longint'(pz[i]) + floor_frac(longint'(vz[i]) * dtl));
                placed++;
                top = i + 1;
            end
            top_slot = top;
            r.tally = 7'(placed);
        end else begin
            r.tally = 7'(count_live());
            if (cmd == CMD_READ) begin
                r.slot_x = px[idx]; r.slot_y = py[idx]; r.slot_z = pz[idx];
                r.slot_life = life[idx];
            end
        end
        r.scan_limit = 7'(top_slot);
        expected_rsps.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_rsp got, want;
        if (!i_rst_n) begin
            clear_particles();
            gen_word = GOLDEN_SEED;
            gravity = GRAVITY_RESET;
            expected_rsps.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr == 4'h0) begin
                    gen_word = (i_pwdata == 0) ? GOLDEN_SEED : i_pwdata;
                    clear_particles();
                end else if (i_paddr == 4'h8) begin
                    gravity = i_pwdata[31:0];
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                predict_request(got, i_req_mon.cmd, i_req_mon.origin_x, i_req_mon.origin_y,
                                i_req_mon.origin_z, i_req_mon.hit_speed,
                                i_req_mon.burst_size, i_req_mon.step_time,
                                i_req_mon.slot_index);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = {i_rsp_mon.tally, i_rsp_mon.scan_limit, i_rsp_mon.slot_x,
                       i_rsp_mon.slot_y, i_rsp_mon.slot_z, i_rsp_mon.slot_life};
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got !== want) begin
                        $display("%0t: response mismatch, expected %p, actual %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* sim/splash_particle_pool_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// splash_particle_pool_tb: testbench of the splash particle pool
// Drives directed and random spawn, tick, read and status requests with
// bursty traffic and a stalling receiver, writes one of the two registers
// before each random phase, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module splash_particle_pool_tb;
    import spp_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          burst_left = 0;

    spp_in_if  req_ch ();
    spp_out_if rsp_ch ();

    splash_particle_pool dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_ch(req_ch), .o_rsp_ch(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    splash_particle_pool_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_mon(req_ch), .i_rsp_mon(rsp_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls in a pattern whose mode is chosen by bits 9:8 of the cycle counter.
    always @(posedge i_clk) begin
        case (cycle_count[9:8])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ch.ready <= cycle_count[2];
            default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] ox,
                                input logic signed [31:0] oy, input logic signed [31:0] oz,
                                input logic signed [31:0] imp, input logic [6:0] burst,
                                input logic [16:0] dt, input logic [5:0] idx);
        if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        while (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            gap_left--;
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd; req_ch.origin_x <= ox; req_ch.origin_y <= oy;
        req_ch.origin_z <= oz; req_ch.hit_speed <= imp; req_ch.burst_size <= burst;
        req_ch.step_time <= dt; req_ch.slot_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_request();
        int pick;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        w = $urandom;
        if (pick < 30) begin
            send_request(CMD_SPAWN, $urandom, $urandom, $urandom,
                         (pick < 5) ? w : 32'(signed'(w) >>> $urandom_range(8, 31)),
                         (pick < 2) ? 7'($urandom) : 7'($urandom_range(0, 8)),
                         17'($urandom), 6'($urandom));
        end else if (pick < 60) begin
            send_request(CMD_TICK, $urandom, $urandom, $urandom, $urandom, 7'($urandom),
                         (pick < 33) ? 17'($urandom) : 17'($urandom_range(0, 8000)),
                         6'($urandom));
        end else if (pick < 95) begin
            send_request(CMD_READ, $urandom, $urandom, $urandom, $urandom, 7'($urandom),
                         17'($urandom), 6'($urandom));
        end else begin
            send_request(CMD_STATUS, $urandom, $urandom, $urandom, $urandom, 7'($urandom),
                         17'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.origin_x = '0; req_ch.origin_y = '0;
        req_ch.origin_z = '0; req_ch.hit_speed = '0; req_ch.burst_size = '0;
        req_ch.step_time = '0; req_ch.slot_index = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_SPAWN, 32'sh7FFF_FFF0, 32'sh8000_0000, 0, 32'sh8000_0000, 7'd3,
                     0, 0);
        send_request(CMD_SPAWN, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7'd0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd0);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd63);
        send_request(CMD_TICK, 0, 0, 0, 0, 0, 17'd0, 0);
        send_request(CMD_TICK, 0, 0, 0, 0, 0, 17'd4000, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd1);
        send_request(CMD_SPAWN, 1, 2, 3, 32'sd655360, 7'd127, 0, 0);
        send_request(CMD_SPAWN, 1, 2, 3, 0, 7'd5, 0, 0);
        send_request(CMD_STATUS, 0, 0, 0, 0, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0, 0, 0, 17'h1FFFF, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd2);
        send_request(CMD_SPAWN, 0, 0, 0, 0, 7'd64, 0, 0);
        send_request(CMD_TICK, 0, 0, 0, 0, 0, 17'd65536, 0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_reg(4'h0, 64'h0);
                1: write_reg(4'h8, 64'h7FFF_FFFF);
                2: write_reg(4'h8, 64'hFFFF_FFFF_8000_0000);
                3: write_reg(4'h0, 64'hFFFF_FFFF_FFFF_FFFF);
                4: write_reg(4'h8, 64'h0);
                5: write_reg(4'h0, {$urandom, $urandom});
                6: write_reg(4'h8, {32'h0, $urandom});
                default: write_reg(4'h8, 64'd642253);
            endcase
            if (phase == 1) begin
                send_request(CMD_SPAWN, 32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh8001_0000,
                             32'sh7FFF_FFFF, 7'd4, 0, 0);
                for (int k = 0; k < 6; k++) begin
                    send_request(CMD_TICK, 0, 0, 0, 0, 0, 17'd60000, 0);
                end
                send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 6'd0);
            end
            for (int n = 0; n < 100; n++) random_request();
            drain();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/spp_pkg.sv
rtl/spp_if.sv
rtl/spp_ram.sv
rtl/spp_mul.sv
rtl/splash_particle_pool.sv
sim/splash_particle_pool_checker.sv
sim/splash_particle_pool_tb.sv
